// File: hdl/tbp_pkg.sv
package tbp_pkg;

  // Header block geometry
  localparam int BLOCK_BYTES = 512;

  // Field offsets and lengths inside the header block
  localparam int MODE_START   = 100;
  localparam int MODE_LEN     = 8;
  localparam int SIZE_START   = 124;
  localparam int SIZE_LEN     = 12;
  localparam int CHK_START    = 148;
  localparam int CHK_LEN      = 8;
  localparam int FLAG_POS     = 156;
  localparam int MAGIC_START  = 257;
  localparam int MAGIC_LEN    = 5;
  localparam int PREFIX_POS   = 345;

  // Value widths
  localparam int SIZE_W       = 36;
  localparam int MODE_W       = 24;
  localparam int CHK_W        = 24;
  localparam int SUM_W        = 17;
  localparam int BLOCKS_W     = 28;
  localparam int BLOCK_SHIFT  = 9;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DIR   = 8'h35;  // '5'
  localparam logic [7:0] CHAR_SYM   = 8'h32;  // '2'
  localparam logic [7:0] CHAR_HARD  = 8'h31;  // '1'

  typedef enum logic [1:0] {
    KIND_REGULAR = 2'd0,
    KIND_DIR     = 2'd1,
    KIND_SYMLINK = 2'd2,
    KIND_HARD    = 2'd3
  } kind_e;

  // Expected magic, one character per offset from the magic start
  function automatic logic [7:0] ustar_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h75;  // u
      3'd1:    c = 8'h73;  // s
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h61;  // a
      3'd4:    c = 8'h72;  // r
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: hdl/tar_header_block_parser_core.sv
// Channel  | Dir | Word                                   | Handshake
// ---------+-----+----------------------------------------+----------------------
// s_axis   | in  | tdata[7:0] header byte                 | tvalid/tready
// m_axis   | out | tdata[103:0] parse result, tuser[2:0]  | tvalid/tready
//
// One header byte is taken per cycle while s_axis_tready is high; the result of a
// 512-byte block appears in the output register in the cycle after its last byte.
// The running state registers (sum, octal fields, flags) are updated as each
// byte is accepted; the result is formed from them in a single pass on the last.
// Reset (rst_ni, asynchronous, active low) clears all parse state and the output.
// Bytes keep flowing while a result waits; only the last byte of the next block
// is held off until the pending result has been taken.
module tar_header_block_parser_core #(
  parameter int BLOCK_BYTES = tbp_pkg::BLOCK_BYTES
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // header byte stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,   // [7:0] header_byte
  // result stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata, low bit up: [0] checksum_ok, [36:1] entry_size, [60:37] entry_mode,
  // [68:61] type_flag, [96:69] data_blocks, [97] non_ustar, [98] has_prefix,
  // [103:99] zero
  output logic [103:0] m_axis_tdata_o,
  // tuser, low bit up: [0] end_block, [2:1] entry_kind
  output logic [2:0]   m_axis_tuser_o
);

  localparam int PosW = $clog2(BLOCK_BYTES);
  localparam logic [PosW-1:0] LastPos = PosW'(BLOCK_BYTES - 1);

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  logic [PosW-1:0] pos_q;
  logic            out_valid_q;
  logic            is_last;
  logic            in_word;
  logic            done;

  assign is_last         = (pos_q == LastPos);
  assign s_axis_tready_o = !is_last || !out_valid_q || m_axis_tready_i;
  assign in_word         = s_axis_tvalid_i && s_axis_tready_o;
  assign done            = in_word && is_last;

  // ---------------------------------------------------------------------------
  // Field windows, decoded from the byte position
  // ---------------------------------------------------------------------------
  logic in_mode, in_size, in_chk, at_flag, in_magic, at_magic0, at_prefix;

  assign in_mode   = (pos_q >= PosW'(tbp_pkg::MODE_START)) &&
                     (pos_q <  PosW'(tbp_pkg::MODE_START + tbp_pkg::MODE_LEN));
  assign in_size   = (pos_q >= PosW'(tbp_pkg::SIZE_START)) &&
                     (pos_q <  PosW'(tbp_pkg::SIZE_START + tbp_pkg::SIZE_LEN));
  assign in_chk    = (pos_q >= PosW'(tbp_pkg::CHK_START)) &&
                     (pos_q <  PosW'(tbp_pkg::CHK_START + tbp_pkg::CHK_LEN));
  assign at_flag   = (pos_q == PosW'(tbp_pkg::FLAG_POS));
  assign in_magic  = (pos_q >= PosW'(tbp_pkg::MAGIC_START)) &&
                     (pos_q <  PosW'(tbp_pkg::MAGIC_START + tbp_pkg::MAGIC_LEN));
  assign at_magic0 = (pos_q == PosW'(tbp_pkg::MAGIC_START));
  assign at_prefix = (pos_q == PosW'(tbp_pkg::PREFIX_POS));

  logic [PosW-1:0] magic_off;
  logic [2:0]      magic_idx;
  assign magic_off = pos_q - PosW'(tbp_pkg::MAGIC_START);
  assign magic_idx = magic_off[2:0];

  // ---------------------------------------------------------------------------
  // Octal fields
  // ---------------------------------------------------------------------------
  logic [tbp_pkg::MODE_W-1:0] mode_val;
  logic [tbp_pkg::SIZE_W-1:0] size_val;
  logic [tbp_pkg::CHK_W-1:0]  chk_val;

  tbp_octal_field #(.Width(tbp_pkg::MODE_W)) u_mode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (done),
    .feed_i  (in_word && in_mode),
    .byte_i  (s_axis_tdata_i),
    .value_o (mode_val)
  );

  tbp_octal_field #(.Width(tbp_pkg::SIZE_W)) u_size (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (done),
    .feed_i  (in_word && in_size),
    .byte_i  (s_axis_tdata_i),
    .value_o (size_val)
  );

  tbp_octal_field #(.Width(tbp_pkg::CHK_W)) u_chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (done),
    .feed_i  (in_word && in_chk),
    .byte_i  (s_axis_tdata_i),
    .value_o (chk_val)
  );

  // ---------------------------------------------------------------------------
  // Running sum and flags
  // ---------------------------------------------------------------------------
  logic [tbp_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [7:0]                sum_byte;
  logic                      nonzero_q, nonzero_d;
  logic [7:0]                flag_q;
  logic                      magic_nz_q, magic_bad_q;
  logic                      prefix_q;

  // checksum bytes count as spaces
  assign sum_byte  = in_chk ? tbp_pkg::CHAR_SPACE : s_axis_tdata_i;
  assign sum_d     = sum_q + tbp_pkg::SUM_W'(sum_byte);
  assign nonzero_d = nonzero_q || (s_axis_tdata_i != 8'h00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      sum_q       <= '0;
      nonzero_q   <= 1'b0;
      flag_q      <= '0;
      magic_nz_q  <= 1'b0;
      magic_bad_q <= 1'b0;
      prefix_q    <= 1'b0;
    end else if (done) begin
      pos_q       <= '0;
      sum_q       <= '0;
      nonzero_q   <= 1'b0;
      flag_q      <= '0;
      magic_nz_q  <= 1'b0;
      magic_bad_q <= 1'b0;
      prefix_q    <= 1'b0;
    end else if (in_word) begin
      pos_q     <= pos_q + PosW'(1);
      sum_q     <= sum_d;
      nonzero_q <= nonzero_d;
      if (at_flag) begin
        flag_q <= s_axis_tdata_i;
      end
      if (at_magic0 && (s_axis_tdata_i != 8'h00)) begin
        magic_nz_q <= 1'b1;
      end
      if (in_magic && (s_axis_tdata_i != tbp_pkg::ustar_char(magic_idx))) begin
        magic_bad_q <= 1'b1;
      end
      if (at_prefix && (s_axis_tdata_i != 8'h00)) begin
        prefix_q <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result, formed on the last byte
  // ---------------------------------------------------------------------------
  tbp_pkg::kind_e                  kind;
  logic [tbp_pkg::SIZE_W:0]        size_round;
  logic [tbp_pkg::BLOCKS_W-1:0]    blocks;
  logic                            chk_ok;

  always_comb begin
    case (flag_q)
      tbp_pkg::CHAR_DIR:  kind = tbp_pkg::KIND_DIR;
      tbp_pkg::CHAR_SYM:  kind = tbp_pkg::KIND_SYMLINK;
      tbp_pkg::CHAR_HARD: kind = tbp_pkg::KIND_HARD;
      default:            kind = tbp_pkg::KIND_REGULAR;
    endcase
  end

  // round up to whole data blocks
  assign size_round = {1'b0, size_val} +
                      (tbp_pkg::SIZE_W + 1)'((1 << tbp_pkg::BLOCK_SHIFT) - 1);
  assign blocks = (kind == tbp_pkg::KIND_REGULAR) ?
                  size_round[tbp_pkg::BLOCK_SHIFT +: tbp_pkg::BLOCKS_W] : '0;
  assign chk_ok = (chk_val == tbp_pkg::CHK_W'(sum_d));

  logic                         end_block_q, chk_ok_q, non_ustar_q, has_prefix_q;
  logic [tbp_pkg::SIZE_W-1:0]   size_q;
  logic [tbp_pkg::MODE_W-1:0]   mode_q;
  logic [7:0]                   type_flag_q;
  logic [1:0]                   kind_q;
  logic [tbp_pkg::BLOCKS_W-1:0] blocks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_block_q  <= 1'b0;
      chk_ok_q     <= 1'b0;
      size_q       <= '0;
      mode_q       <= '0;
      type_flag_q  <= '0;
      kind_q       <= '0;
      blocks_q     <= '0;
      non_ustar_q  <= 1'b0;
      has_prefix_q <= 1'b0;
    end else if (done) begin
      end_block_q  <= !nonzero_d;
      chk_ok_q     <= chk_ok;
      size_q       <= size_val;
      mode_q       <= mode_val;
      type_flag_q  <= flag_q;
      kind_q       <= kind;
      blocks_q     <= blocks;
      non_ustar_q  <= magic_nz_q && magic_bad_q;
      has_prefix_q <= prefix_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, has_prefix_q, non_ustar_q, blocks_q, type_flag_q,
                            mode_q, size_q, chk_ok_q};
  assign m_axis_tuser_o  = {kind_q, end_block_q};

endmodule

// File: hdl/tbp_octal_field.sv
// Octal field accumulator: digits shift in three bits at a time, first
// non-digit freezes the field until the next block.
module tbp_octal_field #(
  parameter int Width = tbp_pkg::SIZE_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             feed_i,
  input  logic [7:0]       byte_i,
  output logic [Width-1:0] value_o
);

  logic [Width-1:0] acc_q;
  logic             stopped_q;
  logic             is_digit;

  assign is_digit = byte_i inside {[8'h30:8'h37]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      stopped_q <= 1'b0;
    end else if (clear_i) begin
      acc_q     <= '0;
      stopped_q <= 1'b0;
    end else if (feed_i && !stopped_q) begin
      if (is_digit) begin
        acc_q <= {acc_q[Width-4:0], byte_i[2:0]};
      end else begin
        stopped_q <= 1'b1;
      end
    end
  end

  assign value_o = acc_q;

endmodule
